/* rtl/smm_pkg.sv */
// Shared constants and types for the square matrix multiplier.
package smm_pkg;

  // Field widths of the command and result transactions.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COORD_W = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DIM_W   = 4;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register map, as indexes in 4-byte steps.
  localparam logic REG_DIMENSION = 1'b0;

  // Reset value of the dimension register.
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Per-cycle control that travels with one multiply-accumulate term.
  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

/* rtl/smm_if.sv */
// Command and result channel interfaces of the square matrix multiplier.
interface smm_cmd_if
  import smm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [COORD_W-1:0]        row;
  logic [COORD_W-1:0]        col;
  logic signed [DATA_W-1:0]  element;

  modport source (output valid, command, row, col, element, input ready);
  modport sink   (input valid, command, row, col, element, output ready);
endinterface

interface smm_res_if
  import smm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [COORD_W-1:0]        out_row;
  logic [COORD_W-1:0]        out_col;
  logic signed [DATA_W-1:0]  product;
  logic                      last;

  modport source (output valid, out_row, out_col, product, last, input ready);
  modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

/* rtl/smm_store.sv */
// Matrix element memory with per-entry valid bits and a registered read port.
module smm_store
  import smm_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DATA_W-1:0] rd_word;
  logic              rd_valid;

  // Storage array; written only while the sequencer is idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word <= mem[raddr];
  end

  // Valid bits stand in for zeroing the array after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  // An entry never written reads as zero.
  assign rdata = rd_valid ? rd_word : '0;

endmodule

/* rtl/smm_mac.sv */
// Shared multiply-accumulate unit with a product register before the adder.
module smm_mac
  import smm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mac_ctl_t          ctl,
  input  logic [DATA_W-1:0] a_data,
  input  logic [DATA_W-1:0] b_data,
  output logic [DATA_W-1:0] acc,
  output logic              done
);

  mac_ctl_t          s1_ctl;
  mac_ctl_t          s2_ctl;
  logic [DATA_W-1:0] prod;

  // Control flags follow the store read and the multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      done   <= 1'b0;
    end else begin
      s1_ctl <= ctl;
      s2_ctl <= s1_ctl;
      done   <= s2_ctl.issue & s2_ctl.last;
    end
  end

  // Low 32 bits of the product, then a wrapping accumulate.
  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
    if (s2_ctl.issue) begin
      acc <= s2_ctl.first ? prod : acc + prod;
    end
  end

endmodule

/* rtl/smm_ctrl.sv */
// Sequencer that walks rows, columns and terms of the product.
module smm_ctrl
  import smm_pkg::*;
#(
  parameter int unsigned MAX_DIM = 8,
  parameter int unsigned CW      = 3,
  parameter int unsigned AW      = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIM_W-1:0]   dimension,
  input  logic               mac_done,
  input  logic               res_ready,
  output logic               cmd_ready,
  output logic               res_valid,
  output mac_ctl_t           ctl,
  output logic [AW-1:0]      a_raddr,
  output logic [AW-1:0]      b_raddr,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic               out_last
);

  state_t         state, state_next;
  logic [CW-1:0]  i, i_next;
  logic [CW-1:0]  j, j_next;
  logic [CW-1:0]  k, k_next;
  logic [CW-1:0]  dim_m1, dim_m1_next;
  logic [DIM_W-1:0] dim_clamped;

  // State and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    i      <= i_next;
    j      <= j_next;
    k      <= k_next;
    dim_m1 <= dim_m1_next;
  end

  // Out-of-range dimensions are clamped into one through MAX_DIM.
  always_comb begin
    if (dimension == '0) begin
      dim_clamped = DIM_W'(1);
    end else if (dimension > DIM_W'(MAX_DIM)) begin
      dim_clamped = DIM_W'(MAX_DIM);
    end else begin
      dim_clamped = dimension;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next  = state;
    i_next      = i;
    j_next      = j;
    k_next      = k;
    dim_m1_next = dim_m1;
    cmd_ready   = 1'b0;
    res_valid   = 1'b0;
    ctl         = '0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (start) begin
          dim_m1_next = CW'(dim_clamped - DIM_W'(1));
          i_next      = '0;
          j_next      = '0;
          k_next      = '0;
          state_next  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        ctl.issue = 1'b1;
        ctl.first = (k == '0);
        ctl.last  = (k == dim_m1);
        if (k == dim_m1) begin
          k_next     = '0;
          state_next = ST_DRAIN;
        end else begin
          k_next = k + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (j == dim_m1) begin
            j_next = '0;
            if (i == dim_m1) begin
              state_next = ST_IDLE;
            end else begin
              i_next     = i + CW'(1);
              state_next = ST_ISSUE;
            end
          end else begin
            j_next     = j + CW'(1);
            state_next = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Row-major addresses of A[i][k] and B[k][j].
  assign a_raddr = AW'(i * MAX_DIM + k);
  assign b_raddr = AW'(k * MAX_DIM + j);

  // Coordinates of the element being emitted.
  assign out_row  = COORD_W'(i);
  assign out_col  = COORD_W'(j);
  assign out_last = (i == dim_m1) && (j == dim_m1);

endmodule

/* rtl/square_matrix_multiply_top.sv */
// Top level of the square matrix multiplier.
//
//   Channel   Direction  Carries
//   cmd_ch    in         command, row, col, element
//   res_ch    out        out_row, out_col, product, last
//   APB       in/out     dimension register at byte address 0
//
// A compute transaction holds cmd_ch.ready low and emits d*d results; each
// result passes its d terms through the one shared multiply-accumulate unit,
// then the store read, product and accumulator registers and the output
// state, and waits while res_ch.ready is low. Reset is synchronous and clears
// the stores at once through per-entry valid bits; no clearing pass.
module square_matrix_multiply_top
  import smm_pkg::*;
#(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  smm_cmd_if.sink               cmd_ch,
  smm_res_if.source             res_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [DIM_W-1:0]  dimension;
  logic              cmd_accept;
  logic              in_range;
  logic [AW-1:0]     waddr;
  logic              a_we;
  logic              b_we;
  logic [AW-1:0]     a_raddr;
  logic [AW-1:0]     b_raddr;
  logic [DATA_W-1:0] a_data;
  logic [DATA_W-1:0] b_data;
  logic [DATA_W-1:0] acc;
  logic              mac_done;
  mac_ctl_t          ctl;

  // Dimension register, written in the APB access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2:2] == REG_DIMENSION)) begin
      dimension <= pwdata[DIM_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_DIMENSION) ?
                  APB_DATA_W'(dimension) : '0;

  // Load decode; writes outside the store are dropped.
  assign cmd_accept = cmd_ch.valid && cmd_ch.ready;
  assign in_range   = (int'(cmd_ch.row) < MAX_DIM) && (int'(cmd_ch.col) < MAX_DIM);
  assign waddr      = AW'(cmd_ch.row * MAX_DIM + cmd_ch.col);
  assign a_we       = cmd_accept && in_range && (cmd_ch.command == CMD_LOAD_A);
  assign b_we       = cmd_accept && in_range && (cmd_ch.command == CMD_LOAD_B);

  smm_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk   (clk),
    .rst   (rst),
    .we    (a_we),
    .waddr (waddr),
    .wdata (cmd_ch.element),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  smm_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk   (clk),
    .rst   (rst),
    .we    (b_we),
    .waddr (waddr),
    .wdata (cmd_ch.element),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  smm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .a_data (a_data),
    .b_data (b_data),
    .acc    (acc),
    .done   (mac_done)
  );

  smm_ctrl #(.MAX_DIM(MAX_DIM), .CW(CW), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd_accept && (cmd_ch.command == CMD_COMPUTE)),
    .dimension (dimension),
    .mac_done  (mac_done),
    .res_ready (res_ch.ready),
    .cmd_ready (cmd_ch.ready),
    .res_valid (res_ch.valid),
    .ctl       (ctl),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .out_row   (res_ch.out_row),
    .out_col   (res_ch.out_col),
    .out_last  (res_ch.last)
  );

  // The accumulator holds the finished element while it is offered.
  assign res_ch.product = acc;

endmodule

/* rtl/smm_check.sv */
// Port-level checker for the square matrix multiplier, bound to the top level.
module smm_check
  import smm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic [CMD_W-1:0]   command,
  input logic               res_valid,
  input logic               res_ready,
  input logic [DATA_W-1:0]  product,
  input logic               res_last
);

  // No new command is taken while a result is offered.
  a_busy_on_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !cmd_ready)
    else $error("command channel ready while a result is pending");

  // A compute transaction makes the block busy on the next cycle.
  a_busy_after_compute: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && (command == CMD_COMPUTE)) |=> !cmd_ready)
    else $error("block still ready after a compute transaction");

  // A load or reserved command leaves the block ready in the next cycle.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && (command != CMD_COMPUTE)) |=> cmd_ready)
    else $error("block not ready after a load transaction");

  // The block returns to ready after the last result of a run.
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res_last) |=> (cmd_ready && !res_valid))
    else $error("block not idle after the last result");

  // A stalled result keeps its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(product)))
    else $error("stalled result changed or dropped");

endmodule

bind square_matrix_multiply_top smm_check u_smm_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_ch.valid),
  .cmd_ready (cmd_ch.ready),
  .command   (cmd_ch.command),
  .res_valid (res_ch.valid),
  .res_ready (res_ch.ready),
  .product   (res_ch.product),
  .res_last  (res_ch.last)
);

/* dv/tb_top.sv */
// Self-checking testbench for the square matrix multiplier top level.
`timescale 1ns / 1ps

module tb_top;
  import smm_pkg::*;

  localparam int unsigned MAX_DIM = 8;
  localparam int unsigned ITEM_GOAL = 350;
  localparam int unsigned STALL_LIMIT = 3000;
  // Settling wait, sized from the largest dimension plus the pipeline.
  localparam int unsigned SETTLE_CYCLES = 2 * (MAX_DIM + 4);
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] DIM_ADDR = APB_ADDR_W'(4 * REG_DIMENSION);

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table; value holds the dimension on a config row.
  typedef struct packed {
    row_kind_t          kind;
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DATA_W-1:0]  value;
    logic               typed;
    logic [DATA_W-1:0]  typed_product;
  } step_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DATA_W-1:0]  product;
    logic               last;
  } product_t;

  localparam int DIRECTED_ROWS = 25;

  // Directed table. Typed products apply to every element of that compute.
  step_t directed [DIRECTED_ROWS] = '{
    '{ROW_ITEM, CMD_COMPUTE,  3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_CFG,  CMD_LOAD_A,   3'd0, 3'd0, 32'd1,         1'b0, 32'h0},
    '{ROW_ITEM, CMD_LOAD_A,   3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_LOAD_B,   3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_COMPUTE,  3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h8000_0000},
    '{ROW_ITEM, CMD_LOAD_A,   3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_LOAD_B,   3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_COMPUTE,  3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{ROW_ITEM, CMD_RESERVED, 3'd0, 3'd0, 32'h0000_0005, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_COMPUTE,  3'd5, 3'd3, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{ROW_ITEM, CMD_LOAD_A,   3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_LOAD_B,   3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_LOAD_A,   3'd0, 3'd7, 32'h1234_5678, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_COMPUTE,  3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{ROW_CFG,  CMD_LOAD_A,   3'd0, 3'd0, 32'd0,         1'b0, 32'h0},
    '{ROW_ITEM, CMD_COMPUTE,  3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{ROW_CFG,  CMD_LOAD_A,   3'd0, 3'd0, 32'd15,        1'b0, 32'h0},
    '{ROW_ITEM, CMD_LOAD_B,   3'd7, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_COMPUTE,  3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_CFG,  CMD_LOAD_A,   3'd0, 3'd0, 32'd8,         1'b0, 32'h0},
    '{ROW_ITEM, CMD_LOAD_A,   3'd7, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_COMPUTE,  3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_CFG,  CMD_LOAD_A,   3'd0, 3'd0, 32'd2,         1'b0, 32'h0},
    '{ROW_ITEM, CMD_LOAD_B,   3'd1, 3'd1, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_ITEM, CMD_COMPUTE,  3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  smm_cmd_if cmd_ch ();
  smm_res_if res_ch ();

  square_matrix_multiply_top #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the matrix stores and the dimension register.
  logic [DATA_W-1:0] a_shadow [MAX_DIM*MAX_DIM];
  logic [DATA_W-1:0] b_shadow [MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]  dim_shadow = DIM_RESET;

  product_t    pending_products[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned computes_sent = 0;
  int unsigned products_checked = 0;
  int unsigned dim_writes = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  initial begin
    foreach (a_shadow[n]) begin
      a_shadow[n] = '0;
      b_shadow[n] = '0;
    end
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (steady || p < 55) begin
      return 0;
    end
    if (p < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Element values lean toward the corners of the signed range.
  function automatic logic [DATA_W-1:0] pick_element();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      4: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned active_dim();
    if (dim_shadow == 0) begin
      return 1;
    end
    if (dim_shadow > MAX_DIM) begin
      return MAX_DIM;
    end
    return dim_shadow;
  endfunction

  // Queue every element of A x B over the active block, in row-major order.
  function automatic void predict_products(input step_t s);
    int unsigned d;
    logic [DATA_W-1:0] acc;
    product_t p;
    d = active_dim();
    for (int unsigned i = 0; i < d; i++) begin
      for (int unsigned j = 0; j < d; j++) begin
        acc = '0;
        for (int unsigned k = 0; k < d; k++) begin
          acc = acc + a_shadow[i*MAX_DIM + k] * b_shadow[k*MAX_DIM + j];
        end
        p.row = COORD_W'(i);
        p.col = COORD_W'(j);
        p.product = s.typed ? s.typed_product : acc;
        p.last = (i + 1 == d) && (j + 1 == d);
        pending_products.push_back(p);
      end
    end
  endfunction

  // Apply one accepted command transaction to the shadow state.
  function automatic void apply_command(input step_t s);
    case (s.cmd)
      CMD_LOAD_A: a_shadow[s.row*MAX_DIM + s.col] = s.value;
      CMD_LOAD_B: b_shadow[s.row*MAX_DIM + s.col] = s.value;
      CMD_COMPUTE: begin
        predict_products(s);
        computes_sent++;
      end
      default: ;
    endcase
    if (s.cmd != CMD_RESERVED) begin
      items_sent++;
    end
  endfunction

  // Present one command transaction and hold it until it is accepted.
  task automatic send_command(input step_t s);
    int unsigned gap;
    gap = pick_gap(send_steady);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= s.cmd;
    cmd_ch.row     <= s.row;
    cmd_ch.col     <= s.col;
    cmd_ch.element <= s.value;
    do @(posedge clk); while (!cmd_ch.ready);
    apply_command(s);
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input int unsigned r,
                           input int unsigned c, input logic [DATA_W-1:0] v);
    step_t s;
    s = '{ROW_ITEM, cmd, COORD_W'(r), COORD_W'(c), v, 1'b0, '0};
    send_command(s);
  endtask

  // Drain every expected result, then let in-flight work finish.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase register write of the dimension.
  task automatic write_dimension(input logic [DIM_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIM_ADDR;
    pwdata  <= APB_DATA_W'(d);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dim_shadow = d;
    dim_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Occasional noise: a reserved command or a load outside the active block.
  task automatic maybe_noise(input int unsigned d);
    if ($urandom_range(0, 9) != 0) begin
      return;
    end
    if (d < MAX_DIM && $urandom_range(0, 1) == 1) begin
      send_item($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                $urandom_range(d, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                pick_element());
    end else begin
      send_item(CMD_RESERVED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
    end
  endtask

  // Result side: random back-pressure and comparison against the prediction.
  initial begin
    product_t want;
    int unsigned stall_left;
    int unsigned stall;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (pending_products.size() == 0) begin
          $error("unexpected result transaction: out_row %0d out_col %0d product %h",
                 res_ch.out_row, res_ch.out_col, res_ch.product);
          errors++;
        end else begin
          want = pending_products.pop_front();
          products_checked++;
          if (res_ch.out_row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, res_ch.out_row);
            errors++;
          end
          if (res_ch.out_col !== want.col) begin
            $error("out_col: expected %0d, actual %0d", want.col, res_ch.out_col);
            errors++;
          end
          if (res_ch.product !== want.product) begin
            $error("product: expected %h, actual %h", want.product, res_ch.product);
            errors++;
          end
          if (res_ch.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, res_ch.last);
            errors++;
          end
        end
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? pick_gap(recv_steady) : 0;
        if (stall != 0) begin
          res_ch.ready <= 1'b0;
          stall_left = stall - 1;
        end else begin
          res_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    int unsigned d;
    int unsigned pick;
    logic [DIM_W-1:0] dim_value;
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CMD_LOAD_A;
    cmd_ch.row     <= '0;
    cmd_ch.col     <= '0;
    cmd_ch.element <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed[n]) begin
      if (directed[n].kind == ROW_CFG) begin
        settle();
        write_dimension(directed[n].value[DIM_W-1:0]);
      end else begin
        send_command(directed[n]);
      end
    end

    // Random phases: a dimension setting, then loads, computes and noise.
    while (items_sent < ITEM_GOAL) begin
      settle();
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        dim_value = DIM_W'($urandom_range(1, 4));
      end else if (pick == 6) begin
        dim_value = DIM_W'(MAX_DIM);
      end else if (pick == 7) begin
        dim_value = DIM_W'($urandom_range(5, MAX_DIM - 1));
      end else if (pick == 8) begin
        dim_value = '0;
      end else begin
        dim_value = DIM_W'($urandom_range(MAX_DIM + 1, 15));
      end
      write_dimension(dim_value);
      d = active_dim();
      repeat ($urandom_range(1, 3)) begin
        if (d <= 4) begin
          // Small blocks are filled almost completely.
          for (int unsigned r = 0; r < d; r++) begin
            for (int unsigned c = 0; c < d; c++) begin
              maybe_noise(d);
              if ($urandom_range(0, 5) != 0) begin
                send_item(CMD_LOAD_A, r, c, pick_element());
              end
              if ($urandom_range(0, 5) != 0) begin
                send_item(CMD_LOAD_B, r, c, pick_element());
              end
            end
          end
        end else begin
          // Large blocks get a handful of scattered updates.
          repeat ($urandom_range(4, 16)) begin
            maybe_noise(d);
            send_item($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                      $urandom_range(0, d - 1), $urandom_range(0, d - 1), pick_element());
          end
        end
        send_item(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      end
    end

    // Wind down.
    send_steady = 1'b0;
    recv_steady = 1'b0;
    cmd_ch.valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d commands, %0d of them computes, over %0d dimension settings.",
             items_sent, computes_sent, dim_writes);
    $display("Compared %0d product elements; %0d mismatches.", products_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/smm_pkg.sv
rtl/smm_if.sv
rtl/smm_store.sv
rtl/smm_mac.sv
rtl/smm_ctrl.sv
rtl/square_matrix_multiply_top.sv
rtl/smm_check.sv
dv/tb_top.sv
